// File: hw/rtl/scd_pkg.sv
// Shared constants, register codes, sequencer steps and the control bundle
// of the stereo chorus. No dependencies.
package scd_pkg;

  localparam int DELAY_DEPTH = 2048;
  localparam int SAMPLE_BITS = 24;

  // Register port widths and codes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 19;
  localparam int LFO_W      = 16;
  localparam int DLY_W      = 19;
  localparam int PHASE_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CHORUS_ON   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DEPTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 8'd3;

  localparam logic [LFO_W-1:0] LFO_STEP_RST    = 16'd302;
  localparam logic [DLY_W-1:0] SWEEP_DEPTH_RST = 19'd25805;
  localparam logic [DLY_W-1:0] BASE_DELAY_RST  = 19'd39322;

  // 0.7 in Q1.15.
  localparam logic signed [15:0] GAIN_Q15 = 16'sd22938;

  // Sequencer steps of one enabled sample.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_WRITE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_DELAY  = 4'd1;
  localparam logic [STEP_W-1:0] ST_POS    = 4'd2;
  localparam logic [STEP_W-1:0] ST_RD_L0  = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD_L1  = 4'd4;
  localparam logic [STEP_W-1:0] ST_RD_R0  = 4'd5;
  localparam logic [STEP_W-1:0] ST_RD_R1  = 4'd6;
  localparam logic [STEP_W-1:0] ST_TAIL_R = 4'd7;
  localparam logic [STEP_W-1:0] ST_TAP_R  = 4'd8;
  localparam logic [STEP_W-1:0] ST_MIX_R  = 4'd9;
  localparam logic [STEP_W-1:0] ST_LAST   = ST_MIX_R;

  typedef struct packed {
    logic              accept;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              chorus;
    logic              load_out;
  } scd_ctrl_t;

endpackage

// File: hw/rtl/scd_store.sv
// Single-port delay memory with registered read data and a clearing pass
// after reset. Depends on scd_pkg.
module scd_store #(
  parameter int DELAY_DEPTH = scd_pkg::DELAY_DEPTH,
  parameter int SAMPLE_BITS = scd_pkg::SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mem_en,
  input  logic                   mem_we,
  input  logic [$clog2(DELAY_DEPTH)-1:0] mem_addr,
  input  logic [SAMPLE_BITS-1:0] mem_wdata,
  output logic [SAMPLE_BITS-1:0] mem_rdata,
  output logic                   clr_busy
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [AW-1:0]          clr_addr_r;
  logic                   clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rdata_r <= mem[mem_addr];
      end
    end
  end

  assign mem_rdata = rdata_r;
  assign clr_busy  = clr_busy_r;

endmodule

// File: hw/rtl/scd_ctrl.sv
// Sample sequencer: accepts a request, steps through the memory schedule
// and hands the result to the output register. Depends on scd_pkg.
module scd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              chorus_on,
  input  logic              clr_busy,
  input  logic              out_free,
  output logic              in_stall,
  output scd_pkg::scd_ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [scd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       chorus_r, chorus_nxt;
  logic                       accept;

  assign in_stall = (state_r != S_IDLE) || clr_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    chorus_nxt = chorus_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          chorus_nxt = chorus_on;
          step_nxt   = scd_pkg::ST_WRITE;
          state_nxt  = chorus_on ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == scd_pkg::ST_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= scd_pkg::ST_WRITE;
      chorus_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      chorus_r <= chorus_nxt;
    end
  end

  assign ctrl.accept   = accept;
  assign ctrl.run      = (state_r == S_RUN);
  assign ctrl.step     = step_r;
  assign ctrl.chorus   = chorus_r;
  assign ctrl.load_out = (state_r == S_DONE) && out_free;

endmodule

// File: hw/rtl/scd_datapath.sv
// Sweep, tap address, interpolation and mixing arithmetic; owns the write
// pointer and sweep phase and drives the delay memory. Depends on scd_pkg.
module scd_datapath #(
  parameter int DELAY_DEPTH = scd_pkg::DELAY_DEPTH,
  parameter int SAMPLE_BITS = scd_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scd_pkg::scd_ctrl_t            ctrl,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [scd_pkg::LFO_W-1:0]     lfo_step,
  input  logic [scd_pkg::DLY_W-1:0]     sweep_depth,
  input  logic [scd_pkg::DLY_W-1:0]     base_delay,
  output logic                          mem_en,
  output logic                          mem_we,
  output logic [$clog2(DELAY_DEPTH)-1:0] mem_addr,
  output logic [SAMPLE_BITS-1:0]        mem_wdata,
  input  logic [SAMPLE_BITS-1:0]        mem_rdata,
  output logic [SAMPLE_BITS-1:0]        left_res,
  output logic [SAMPLE_BITS-1:0]        right_res
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int DW   = (AW + 31 > 45) ? AW + 31 : 45;
  localparam int D8_W = AW + 8;
  localparam int P_W  = AW + 9;
  localparam int PR_W = SB + 10;
  localparam int MX_W = SB + 17;
  localparam logic signed [DW-1:0]   TOP      = DW'(DELAY_DEPTH - 4) <<< 30;
  localparam logic [P_W-1:0]         SPAN     = P_W'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]          LAST_IDX = AW'(DELAY_DEPTH - 1);
  localparam logic signed [MX_W-1:0] RND      = MX_W'(16384);
  localparam logic signed [MX_W-1:0] SMAX_X   = MX_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [MX_W-1:0] SMIN_X   = -SMAX_X - MX_W'(1);

  // Clamp a delay in 2^-30 samples to the store range, keep Q.8.
  function automatic logic [D8_W-1:0] to_d8(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] c;
    begin
      if (d < 0) begin
        c = '0;
      end else if (d > TOP) begin
        c = TOP;
      end else begin
        c = d;
      end
      return c[D8_W+21:22];
    end
  endfunction

  // Tap position behind the write pointer: {i0, i1, fraction}.
  function automatic logic [2*AW+7:0] tap_pos(input logic [AW-1:0] wi,
                                              input logic [D8_W-1:0] d8);
    logic [P_W-1:0] t;
    logic [P_W-1:0] p;
    logic [AW-1:0]  i0;
    logic [AW-1:0]  i1;
    begin
      t  = P_W'({wi, 8'd0}) + SPAN - P_W'(d8);
      p  = (t >= SPAN) ? t - SPAN : t;
      i0 = p[AW+7:8];
      i1 = (i0 == LAST_IDX) ? '0 : i0 + 1'b1;
      return {i0, i1, p[7:0]};
    end
  endfunction

  function automatic logic [SB-1:0] sat_out(input logic signed [MX_W-1:0] m);
    logic signed [MX_W-1:0] r;
    begin
      r = (m + RND) >>> 15;
      if (r > SMAX_X) begin
        r = SMAX_X;
      end else if (r < SMIN_X) begin
        r = SMIN_X;
      end
      return r[SB-1:0];
    end
  endfunction

  logic [AW-1:0]                   wi_r;
  logic [scd_pkg::PHASE_W-1:0]     phase_r;
  logic signed [SB-1:0]            x_r;
  logic signed [43:0]              swing_r;
  logic [D8_W-1:0]                 d8l_r, d8r_r;
  logic [AW-1:0]                   i0l_r, i1l_r, i0r_r, i1r_r;
  logic [7:0]                      fl_r, fr_r;
  logic signed [PR_W-1:0]          prod_r, acc_r;
  logic signed [SB-1:0]            tapl_r, tapr_r;
  logic signed [MX_W-1:0]          mixl_r, mixr_r;

  logic signed [23:0]              tri_w;
  logic signed [DW-1:0]            centre_w, swing_x, dl_w, dr_w;
  logic [2*AW+7:0]                 posl_w, posr_w;
  logic [8:0]                      weight_w;
  logic signed [PR_W:0]            tapsum_w;
  logic signed [SB:0]              xtl_w, xtr_w;

  // Triangle in units of 2^-22, range -1..1.
  always_comb begin
    if (!phase_r[23]) begin
      tri_w = $signed(phase_r - 24'h400000);
    end else begin
      tri_w = $signed(24'hC00000 - phase_r);
    end
  end

  assign centre_w = $signed(DW'({base_delay, 22'd0}));
  assign swing_x  = DW'(swing_r);
  assign dl_w     = centre_w + swing_x;
  assign dr_w     = centre_w - swing_x;
  assign posl_w   = tap_pos(wi_r, d8l_r);
  assign posr_w   = tap_pos(wi_r, d8r_r);
  assign tapsum_w = (PR_W + 1)'(acc_r) + (PR_W + 1)'(prod_r);
  assign xtl_w    = (SB + 1)'(x_r) + (SB + 1)'(tapl_r);
  assign xtr_w    = (SB + 1)'(x_r) + (SB + 1)'(tapr_r);

  // Memory access and interpolation weight for the current step.
  always_comb begin
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = wi_r;
    weight_w = 9'd256 - {1'b0, fl_r};
    if (ctrl.run) begin
      unique case (ctrl.step) inside
        scd_pkg::ST_WRITE: begin
          mem_en = 1'b1;
          mem_we = 1'b1;
        end
        scd_pkg::ST_RD_L0: begin
          mem_en   = 1'b1;
          mem_addr = i0l_r;
        end
        scd_pkg::ST_RD_L1: begin
          mem_en   = 1'b1;
          mem_addr = i1l_r;
        end
        scd_pkg::ST_RD_R0: begin
          mem_en   = 1'b1;
          mem_addr = i0r_r;
          weight_w = {1'b0, fl_r};
        end
        scd_pkg::ST_RD_R1: begin
          mem_en   = 1'b1;
          mem_addr = i1r_r;
          weight_w = 9'd256 - {1'b0, fr_r};
        end
        scd_pkg::ST_TAIL_R: begin
          weight_w = {1'b0, fr_r};
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_wdata = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r    <= '0;
      phase_r <= '0;
    end else if (ctrl.run) begin
      if (ctrl.step == scd_pkg::ST_WRITE) begin
        phase_r <= phase_r + scd_pkg::PHASE_W'(lfo_step);
      end
      if (ctrl.step == scd_pkg::ST_POS) begin
        wi_r <= (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      x_r <= in_sample;
    end
    if (ctrl.run) begin
      case (ctrl.step)
        scd_pkg::ST_WRITE: begin
          swing_r <= $signed({1'b0, sweep_depth}) * tri_w;
        end
        scd_pkg::ST_DELAY: begin
          d8l_r <= to_d8(dl_w);
          d8r_r <= to_d8(dr_w);
        end
        scd_pkg::ST_POS: begin
          {i0l_r, i1l_r, fl_r} <= posl_w;
          {i0r_r, i1r_r, fr_r} <= posr_w;
        end
        scd_pkg::ST_RD_L1: begin
          prod_r <= $signed(mem_rdata) * $signed({1'b0, weight_w});
        end
        scd_pkg::ST_RD_R0: begin
          acc_r  <= prod_r;
          prod_r <= $signed(mem_rdata) * $signed({1'b0, weight_w});
        end
        scd_pkg::ST_RD_R1: begin
          tapl_r <= tapsum_w[SB+7:8];
          prod_r <= $signed(mem_rdata) * $signed({1'b0, weight_w});
        end
        scd_pkg::ST_TAIL_R: begin
          acc_r  <= prod_r;
          prod_r <= $signed(mem_rdata) * $signed({1'b0, weight_w});
        end
        scd_pkg::ST_TAP_R: begin
          tapr_r <= tapsum_w[SB+7:8];
          mixl_r <= xtl_w * scd_pkg::GAIN_Q15;
        end
        scd_pkg::ST_MIX_R: begin
          mixr_r <= xtr_w * scd_pkg::GAIN_Q15;
        end
        default: begin
        end
      endcase
    end
  end

  assign left_res  = ctrl.chorus ? sat_out(mixl_r) : x_r;
  assign right_res = ctrl.chorus ? sat_out(mixr_r) : x_r;

endmodule

// File: hw/rtl/stereo_chorus_delay_line.sv
// Top level of the stereo chorus: register file, output register and the
// sequencer, datapath and delay memory. Depends on scd_pkg and submodules.
//
//   channel  direction  handshake                   payload
//   in_      input      in_valid / in_stall         in_sample_in
//   out_     output     out_valid / out_stall       out_left_out, out_right_out
//   cfg_     input      cfg_valid / cfg_ready       cfg_index, cfg_data
//
// With the chorus enabled a request runs through ten sequencer steps for one
// write and four reads on the single memory port, one shared interpolation
// multiplier and two mix products, then the load into the output register;
// the next request is taken only once the load is done. With the chorus
// disabled the steps are skipped and the result goes straight to the load.
// After reset the memory is cleared one entry per cycle with in_stall held
// high; configuration writes are taken throughout.
// A result waits in the output register while out_stall is high, and the
// next request is already accepted; it is finished once the register frees.
module stereo_chorus_delay_line #(
  parameter int DELAY_DEPTH = scd_pkg::DELAY_DEPTH,
  parameter int SAMPLE_BITS = scd_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_left_out,
  output logic signed [SAMPLE_BITS-1:0]       out_right_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);

  // Configuration registers. Writes are always accepted; unknown indexes
  // are dropped and wide data is truncated to the register width.
  logic                        chorus_on_r;
  logic [scd_pkg::LFO_W-1:0]   lfo_step_r;
  logic [scd_pkg::DLY_W-1:0]   sweep_depth_r;
  logic [scd_pkg::DLY_W-1:0]   base_delay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chorus_on_r   <= 1'b0;
      lfo_step_r    <= scd_pkg::LFO_STEP_RST;
      sweep_depth_r <= scd_pkg::SWEEP_DEPTH_RST;
      base_delay_r  <= scd_pkg::BASE_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scd_pkg::REG_CHORUS_ON:   chorus_on_r   <= cfg_data[0];
        scd_pkg::REG_LFO_STEP:    lfo_step_r    <= cfg_data[scd_pkg::LFO_W-1:0];
        scd_pkg::REG_SWEEP_DEPTH: sweep_depth_r <= cfg_data[scd_pkg::DLY_W-1:0];
        scd_pkg::REG_BASE_DELAY:  base_delay_r  <= cfg_data[scd_pkg::DLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scd_pkg::scd_ctrl_t     ctrl;
  logic                   clr_busy;
  logic                   out_free;
  logic                   mem_en;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic [SAMPLE_BITS-1:0] left_res;
  logic [SAMPLE_BITS-1:0] right_res;

  // Output register: free when empty or being taken this cycle.
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] right_r;

  assign out_free = !out_valid_r || !out_stall;

  scd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .chorus_on (chorus_on_r),
    .clr_busy  (clr_busy),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  scd_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_sample   (in_sample_in),
    .lfo_step    (lfo_step_r),
    .sweep_depth (sweep_depth_r),
    .base_delay  (base_delay_r),
    .mem_en      (mem_en),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .left_res    (left_res),
    .right_res   (right_res)
  );

  scd_store #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .clr_busy  (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = $signed(left_r);
  assign out_right_out = $signed(right_r);

endmodule

// File: hw/rtl/scd_checker.sv
// Port-level checks of the stereo chorus and the bind that attaches them
// to the top level. Depends on scd_pkg.
module scd_checker #(
  parameter int SAMPLE_BITS = scd_pkg::SAMPLE_BITS
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [SAMPLE_BITS-1:0]         out_left_out,
  input logic [SAMPLE_BITS-1:0]         out_right_out
);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_out)
                               && $stable(out_right_out))
    else $error("result changed while stalled");

  // The block is busy with a request right after taking it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one is in flight");

  // The memory clearing pass keeps the input closed out of reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open before the memory was cleared");

  // A new result only appears after the block has been working on it.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

endmodule

bind stereo_chorus_delay_line scd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_scd_checker (.*);
